// ===== design/gji_pkg.sv =====
package gji_pkg;

    localparam int MAX_N_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 24;
    localparam int SIZE_W         = 4;
    localparam int ELEM_W         = 32;
    localparam int STATUS_W       = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

    // Command handed from the loader to the solver.
    typedef struct packed {
        logic [SIZE_W:0] n;
    } gji_cmd_t;

    // Solver sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_PIV_RD,
        ST_PIV_WT,
        ST_ROW_RD,
        ST_ROW_WT,
        ST_DIV,
        ST_OP_RD,
        ST_OP_WT,
        ST_OP_MUL,
        ST_OP_SUB,
        ST_OP_WR,
        ST_NRM_RD,
        ST_NRM_WT,
        ST_NRM_DIV,
        ST_NM_RD,
        ST_NM_WT,
        ST_NM_MUL,
        ST_NM_WR,
        ST_OUT_RD,
        ST_OUT_WT,
        ST_OUT_HOLD
    } gji_state_t;

endpackage

// ===== design/gji_div.sv =====
// Restoring divider producing clamp((a << FRAC) / b), truncated toward zero.
module gji_div #(
    parameter int DATA_WIDTH = gji_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] num,
    input  logic [DATA_WIDTH-1:0] den,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quo,
    output logic                  sat
);
    import gji_pkg::*;

    localparam int NW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW:0] QMAX = {{(FRAC_BITS + 1){1'b0}}, 1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic [NW-1:0] dvd_reg, dvd_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DATA_WIDTH:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dsr_reg, dsr_next;
    logic neg_reg, neg_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [DATA_WIDTH-1:0] abs_a, abs_b;
    logic [DATA_WIDTH:0] trial, shifted;
    logic [NW:0] mag;
    logic [NW:0] lim;

    assign abs_a = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
    assign abs_b = den[DATA_WIDTH-1] ? (~den + 1'b1) : den;

    // One quotient bit per cycle.
    always_comb
    begin
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg[DATA_WIDTH-1:0], dvd_reg[NW-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            dvd_next  = {abs_a, {FRAC_BITS{1'b0}}};
            q_next    = '0;
            rem_next  = '0;
            dsr_next  = abs_b;
            neg_next  = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[NW-2:0], 1'b0};
            if (!trial[DATA_WIDTH])
            begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    // Sign and clamp the magnitude.
    assign mag = {1'b0, q_reg};
    assign lim = neg_reg ? QMAX + 1'b1 : QMAX;
    always_comb
    begin
        sat = 1'b0;
        if (mag > lim)
        begin
            sat = 1'b1;
            quo = neg_reg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        else
        begin
            quo = neg_reg ? (~q_reg[DATA_WIDTH-1:0] + 1'b1) : q_reg[DATA_WIDTH-1:0];
        end
    end
    assign done = done_reg;

endmodule

// ===== design/gji_load.sv =====
// Front part: counts elements into the work store and issues a solve command.
module gji_load #(
    parameter int MAX_N      = gji_pkg::MAX_N_DEF,
    parameter int DATA_WIDTH = gji_pkg::DATA_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gji_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [gji_pkg::ELEM_W-1:0]       element_value,
    output logic                             wr_en,
    output logic [2*$clog2(MAX_N)-1:0]       wr_addr,
    output logic [DATA_WIDTH-1:0]            wr_data,
    output logic                             load_sat,
    output logic                             cmd_valid,
    output gji_pkg::gji_cmd_t                cmd,
    input  logic                             cmd_stall
);
    import gji_pkg::*;

    localparam int RW = $clog2(MAX_N);
    localparam int AW = 2 * RW;
    localparam logic signed [ELEM_W:0] VMAX = (ELEM_W+1)'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
    localparam logic signed [ELEM_W:0] VMIN = -VMAX - 1;

    logic [SIZE_W-1:0] size_reg;
    logic [RW:0] row_reg, row_next, col_reg, col_next;
    logic [SIZE_W:0] n;
    logic acc, last;
    logic signed [ELEM_W:0] ext;

    // Effective size: zero acts as one, above MAX_N saturates.
    always_comb
    begin
        n = {1'b0, size_reg};
        if (size_reg == '0)
            n = (SIZE_W+1)'(1);
        else if ({1'b0, size_reg} > (SIZE_W+1)'(MAX_N))
            n = (SIZE_W+1)'(MAX_N);
    end

    // While a solve is queued or running the loader holds off further beats.
    assign in_stall = cmd_valid || cmd_stall;
    assign acc  = in_valid && !in_stall;
    assign last = ((SIZE_W+1)'(row_reg) == n - 1'b1) && ((SIZE_W+1)'(col_reg) == n - 1'b1);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (acc)
        begin
            if (last)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if ((SIZE_W+1)'(col_reg) == n - 1'b1)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        if (cfg_we)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else
        begin
            if (cfg_we)
                size_reg <= cfg_data;
            row_reg <= row_next;
            col_reg <= col_next;
            if (acc && last)
            begin
                cmd_valid <= 1'b1;
                cmd.n     <= n;
            end
            else if (!cmd_stall)
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Store write with input clamp.
    assign ext = (ELEM_W+1)'(signed'(element_value));
    always_comb
    begin
        load_sat = 1'b0;
        wr_data  = DATA_WIDTH'(element_value);
        if (ext > VMAX)
        begin
            load_sat = 1'b1;
            wr_data  = DATA_WIDTH'(VMAX);
        end
        else if (ext < VMIN)
        begin
            load_sat = 1'b1;
            wr_data  = DATA_WIDTH'(VMIN);
        end
    end
    assign wr_en   = acc;
    assign wr_addr = AW'({row_reg[RW-1:0], col_reg[RW-1:0]});

endmodule

// ===== design/gji_solve.sv =====
// Back part: elimination sequencer, the two stores, two multipliers and one shared divider.
module gji_solve #(
    parameter int MAX_N      = gji_pkg::MAX_N_DEF,
    parameter int DATA_WIDTH = gji_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           ld_en,
    input  logic [2*$clog2(MAX_N)-1:0]     ld_addr,
    input  logic [DATA_WIDTH-1:0]          ld_data,
    input  logic                           ld_sat,
    input  logic                           ld_first,
    input  logic                           cmd_valid,
    input  gji_pkg::gji_cmd_t              cmd,
    output logic                           cmd_stall,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [gji_pkg::ELEM_W-1:0]     inverse_value,
    output logic                           last_element,
    output logic [gji_pkg::STATUS_W-1:0]   status_code
);
    import gji_pkg::*;

    localparam int RW = $clog2(MAX_N);
    localparam int AW = 2 * RW;
    localparam int DW = DATA_WIDTH;
    localparam logic signed [2*DW:0] VMAX = (2*DW+1)'((65'sd1 <<< (DW-1)) - 1);
    localparam logic signed [2*DW:0] VMIN = -VMAX - 1;

    logic [DW-1:0] wmem [1 << AW];
    logic [DW-1:0] imem [1 << AW];

    gji_state_t state_reg, state_next;
    logic [RW:0] k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [1:0] phase_reg, phase_next; // 0 down, 1 up
    logic [SIZE_W:0] n_reg;
    logic [1:0] flags_reg;
    logic [DW-1:0] piv_reg, s_reg, wk_reg, ik_reg, wr_reg, ir_reg;
    logic [DW-1:0] wrd_reg, ird_reg;
    logic [DW-1:0] subw_reg, subi_reg;
    logic signed [2*DW-1:0] pw_reg, pi_reg;
    logic [DW-1:0] rw_res, ri_res;
    logic set_z, set_s;

    logic div_start, div_done, div_sat;
    logic [DW-1:0] div_num, div_den, div_q;
    logic [AW-1:0] ra_w, ra_i, wa;
    logic we_w, we_i;
    logic [DW-1:0] wd_w, wd_i;
    logic [RW:0] nm1;
    logic out_acc;

    gji_div #(.DATA_WIDTH(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_q), .sat(div_sat)
    );

    function automatic logic [AW-1:0] adr(input logic [RW:0] r, input logic [RW:0] c);
        adr = AW'({r[RW-1:0], c[RW-1:0]});
    endfunction

    // Q product shifted down with truncation toward zero.
    function automatic logic signed [2*DW:0] qsh(input logic signed [2*DW-1:0] p);
        logic signed [2*DW:0] t;
        t = (2*DW+1)'(p);
        if (p < 0)
            t = t + (2*DW+1)'((65'sd1 <<< FRAC_BITS) - 1);
        qsh = t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [2*DW:0] cl(input logic signed [2*DW:0] v);
        if (v > VMAX)
            cl = VMAX;
        else if (v < VMIN)
            cl = VMIN;
        else
            cl = v;
    endfunction

    function automatic logic ov(input logic signed [2*DW:0] v);
        ov = (v > VMAX) || (v < VMIN);
    endfunction

    assign nm1 = (RW+1)'(n_reg - 1'b1);
    assign out_acc = out_valid && !out_stall;

    // Row operation: product clamp then difference clamp; row scaling clamps the product only.
    logic signed [2*DW:0] qw, qi, dw, di;
    always_comb
    begin
        qw = cl(qsh(pw_reg));
        qi = cl(qsh(pi_reg));
        dw = (2*DW+1)'(signed'(wrd_reg)) - qw;
        di = (2*DW+1)'(signed'(ird_reg)) - qi;
        if (state_reg == ST_OP_SUB)
        begin
            rw_res = DW'(cl(dw));
            ri_res = DW'(cl(di));
            set_s  = ov(qsh(pw_reg)) || ov(qsh(pi_reg)) || ov(dw) || ov(di);
        end
        else
        begin
            rw_res = DW'(qw);
            ri_res = DW'(qi);
            set_s  = ov(qsh(pw_reg)) || ov(qsh(pi_reg));
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        i_next = i_reg;
        j_next = j_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                begin
                    state_next = ST_INIT;
                    i_next = '0;
                    j_next = '0;
                end
            ST_INIT:
                if (j_reg == nm1)
                begin
                    j_next = '0;
                    if (i_reg == nm1)
                    begin
                        k_next = '0;
                        if (nm1 == '0)
                        begin
                            state_next = ST_NRM_RD;
                            i_next = '0;
                        end
                        else
                        begin
                            phase_next = 2'd0;
                            i_next = (RW+1)'(1);
                            state_next = ST_PIV_RD;
                        end
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
            ST_PIV_RD:  state_next = ST_PIV_WT;
            ST_PIV_WT:  state_next = ST_ROW_RD;
            ST_ROW_RD:  state_next = ST_ROW_WT;
            ST_ROW_WT:  state_next = ST_DIV;
            ST_DIV:
                if (div_done || piv_reg == '0)
                begin
                    state_next = ST_OP_RD;
                    j_next = '0;
                end
            ST_OP_RD:   state_next = ST_OP_WT;
            ST_OP_WT:   state_next = ST_OP_MUL;
            ST_OP_MUL:  state_next = ST_OP_SUB;
            ST_OP_SUB:  state_next = ST_OP_WR;
            ST_OP_WR:
                if (j_reg != nm1)
                begin
                    j_next = j_reg + 1'b1;
                    state_next = ST_OP_RD;
                end
                else if (phase_reg == 2'd0)
                begin
                    if (i_reg != nm1)
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = ST_ROW_RD;
                    end
                    else if (k_reg + 1'b1 != nm1)
                    begin
                        k_next = k_reg + 1'b1;
                        i_next = k_reg + 2'd2;
                        state_next = ST_PIV_RD;
                    end
                    else
                    begin
                        phase_next = 2'd1;
                        k_next = nm1;
                        i_next = nm1 - 1'b1;
                        state_next = ST_PIV_RD;
                    end
                end
                else
                begin
                    if (i_reg != '0)
                    begin
                        i_next = i_reg - 1'b1;
                        state_next = ST_ROW_RD;
                    end
                    else if (k_reg != (RW+1)'(1))
                    begin
                        k_next = k_reg - 1'b1;
                        i_next = k_reg - 2'd2;
                        state_next = ST_PIV_RD;
                    end
                    else
                    begin
                        i_next = '0;
                        state_next = ST_NRM_RD;
                    end
                end
            ST_NRM_RD:  state_next = ST_NRM_WT;
            ST_NRM_WT:  state_next = ST_NRM_DIV;
            ST_NRM_DIV:
                if (div_done || piv_reg == '0)
                begin
                    j_next = '0;
                    state_next = ST_NM_RD;
                end
            ST_NM_RD:   state_next = ST_NM_WT;
            ST_NM_WT:   state_next = ST_NM_MUL;
            ST_NM_MUL:  state_next = ST_NM_WR;
            ST_NM_WR:
                if (j_reg != nm1)
                begin
                    j_next = j_reg + 1'b1;
                    state_next = ST_NM_RD;
                end
                else if (i_reg != nm1)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_NRM_RD;
                end
                else
                begin
                    i_next = '0;
                    j_next = '0;
                    state_next = ST_OUT_RD;
                end
            ST_OUT_RD:  state_next = ST_OUT_WT;
            ST_OUT_WT:  state_next = ST_OUT_HOLD;
            ST_OUT_HOLD:
                if (out_acc)
                begin
                    if (j_reg != nm1)
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                    else if (i_reg != nm1)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                    else
                        state_next = ST_IDLE;
                end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: store ports, divider start and operands, command stall.
    always_comb
    begin
        ra_w = adr(i_reg, j_reg);
        ra_i = adr(i_reg, j_reg);
        wa   = adr(i_reg, j_reg);
        we_w = 1'b0;
        we_i = 1'b0;
        wd_w = rw_res;
        wd_i = ri_res;
        div_start = 1'b0;
        div_num = '0;
        div_den = piv_reg;
        cmd_stall = (state_reg != ST_IDLE);
        set_z = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                we_i = 1'b1;
                wd_i = (i_reg == j_reg) ? DW'(65'd1 << FRAC_BITS) : '0;
            end
            ST_PIV_RD:  ra_w = adr(k_reg, k_reg);
            ST_ROW_RD:  ra_w = adr(i_reg, k_reg);
            ST_ROW_WT:
            begin
                div_start = (piv_reg != '0);
                div_num = wrd_reg;
                set_z = (piv_reg == '0);
            end
            ST_DIV:     div_num = wr_reg;
            ST_OP_RD:
            begin
                ra_w = adr(k_reg, j_reg);
                ra_i = adr(k_reg, j_reg);
            end
            ST_OP_WT:
            begin
                ra_w = adr(i_reg, j_reg);
                ra_i = adr(i_reg, j_reg);
            end
            ST_OP_WR:
            begin
                we_w = 1'b1;
                we_i = 1'b1;
                wd_w = subw_reg;
                wd_i = subi_reg;
            end
            ST_NRM_RD:  ra_w = adr(i_reg, i_reg);
            ST_NRM_WT:
            begin
                div_start = (wrd_reg != '0);
                div_num = DW'(65'd1 << FRAC_BITS);
                div_den = wrd_reg;
            end
            ST_NRM_DIV:
            begin
                div_num = DW'(65'd1 << FRAC_BITS);
            end
            ST_NM_WR:
            begin
                we_w = 1'b1;
                we_i = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (ld_en)
        begin
            we_w = 1'b1;
            wa   = ld_addr;
            wd_w = ld_data;
        end
    end

    // Stores: one write, registered reads.
    always_ff @(posedge clk)
    begin
        if (we_w)
            wmem[wa] <= wd_w;
        if (we_i)
            imem[wa] <= wd_i;
        wrd_reg <= wmem[ra_w];
        ird_reg <= imem[ra_i];
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PIV_WT || state_reg == ST_NRM_WT)
            piv_reg <= wrd_reg;
        if (state_reg == ST_ROW_WT)
            wr_reg <= wrd_reg;
        if ((state_reg == ST_DIV || state_reg == ST_NRM_DIV))
        begin
            if (piv_reg == '0)
                s_reg <= '0;
            else if (div_done)
                s_reg <= div_q;
        end
        if (state_reg == ST_OP_WT)
        begin
            wk_reg <= wrd_reg;
            ik_reg <= ird_reg;
        end
        if (state_reg == ST_OP_MUL)
        begin
            pw_reg <= signed'(s_reg) * signed'(wk_reg);
            pi_reg <= signed'(s_reg) * signed'(ik_reg);
        end
        if (state_reg == ST_NM_MUL)
        begin
            pw_reg <= signed'(wrd_reg) * signed'(s_reg);
            pi_reg <= signed'(ird_reg) * signed'(s_reg);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            phase_reg <= '0;
            n_reg <= '0;
            flags_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            i_reg <= i_next;
            j_reg <= j_next;
            phase_reg <= phase_next;
            if (state_reg == ST_IDLE && cmd_valid)
                n_reg <= cmd.n;
            if (ld_en && ld_first)
                flags_reg <= {ld_sat, 1'b0};
            else
            begin
                if (ld_en && ld_sat)
                    flags_reg[1] <= 1'b1;
                if (set_z || (state_reg == ST_NRM_WT && wrd_reg == '0))
                    flags_reg[0] <= 1'b1;
                if ((state_reg == ST_OP_SUB || state_reg == ST_NM_WR) && set_s)
                    flags_reg[1] <= 1'b1;
                if ((state_reg == ST_DIV || state_reg == ST_NRM_DIV) && div_done && div_sat)
                    flags_reg[1] <= 1'b1;
            end
            if (state_reg == ST_OUT_WT)
                out_valid <= 1'b1;
            else if (out_acc)
                out_valid <= 1'b0;
        end
    end

    // Row-operation results held for the write, and result beat registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OP_SUB || state_reg == ST_NM_WR)
        begin
            subw_reg <= rw_res;
            subi_reg <= ri_res;
        end
        if (state_reg == ST_OUT_WT)
        begin
            inverse_value <= ELEM_W'(ird_reg);
            last_element  <= (i_reg == nm1) && (j_reg == nm1);
            status_code   <= flags_reg[0] ? STATUS_ZERO
                           : (flags_reg[1] ? STATUS_SAT : STATUS_OK);
        end
    end

endmodule

// ===== design/gauss_jordan_matrix_inverse.sv =====
// Gauss-Jordan inverse of an n x n signed Q8.24 matrix, without pivoting.
// Input channel: one element per beat on element_value, row-major, with
// in_valid / in_stall. Output channel: one inverse element per beat on
// inverse_value with last_element on the final beat and status_code
// (ok, zero pivot, saturated) constant over the matrix.
// cfg_we / cfg_data set matrix_size (0 acts as 1, above MAX_N clamps) and
// restart the load count. Elements are accepted back to back while
// in_stall is low. After the last element the solver sets up the identity,
// then runs n(n-1) row operations, each with a division on the shared
// radix-2 divider and a multiply-subtract per column, with a pivot read
// per pivot row; then n row scalings, each a division plus a multiply per
// column. Each output beat is read from the inverse store before it is
// presented. The input is stalled from the last element until the final
// result beat is taken. A stalled output beat holds its value. Reset
// clears counters and flags and sets the size to 8.
module gauss_jordan_matrix_inverse #(
    parameter int MAX_N      = gji_pkg::MAX_N_DEF,
    parameter int DATA_WIDTH = gji_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gji_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [gji_pkg::ELEM_W-1:0]     element_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [gji_pkg::ELEM_W-1:0]     inverse_value,
    output logic                           last_element,
    output logic [gji_pkg::STATUS_W-1:0]   status_code
);
    import gji_pkg::*;

    localparam int AW = 2 * $clog2(MAX_N);

    logic wr_en, load_sat, cmd_valid, cmd_stall, ld_first, solve_busy;
    logic [AW-1:0] wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    gji_cmd_t cmd;
    logic load_stall;

    gji_load #(.MAX_N(MAX_N), .DATA_WIDTH(DATA_WIDTH)) u_load (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(load_stall), .element_value(element_value),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .load_sat(load_sat),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_stall(cmd_stall)
    );

    // The work store is shared, so loading waits while the solver runs.
    assign solve_busy = cmd_stall;
    assign in_stall   = load_stall || solve_busy;
    assign ld_first   = (wr_addr == '0);

    gji_solve #(.MAX_N(MAX_N), .DATA_WIDTH(DATA_WIDTH)) u_solve (
        .clk(clk), .rst_n(rst_n), .ld_en(wr_en && !solve_busy), .ld_addr(wr_addr),
        .ld_data(wr_data), .ld_sat(load_sat), .ld_first(ld_first),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_stall(cmd_stall),
        .out_valid(out_valid), .out_stall(out_stall), .inverse_value(inverse_value),
        .last_element(last_element), .status_code(status_code)
    );

    // A result beat holds while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(inverse_value))
        else $error("stalled result changed");

    // No element is taken while the solver owns the store.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> in_stall)
        else $error("element taken during solve");

    // Status never reports an unused code.
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status_code != 2'd3))
        else $error("bad status code");

endmodule
